### rtl/core/stack_machine_executor_top_macros.svh
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Shorthand for clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH

// same-cycle implication
`define SMX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/smx_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, operation numbers and shared arithmetic unit types.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int EXT_W  = 34;
  localparam int WIDE_W = 66;

  localparam logic [3:0] OP_LIT = 4'd1;
  localparam logic [3:0] OP_OPR = 4'd2;
  localparam logic [3:0] OP_LOD = 4'd3;
  localparam logic [3:0] OP_STO = 4'd4;
  localparam logic [3:0] OP_CAL = 4'd5;
  localparam logic [3:0] OP_INC = 4'd6;
  localparam logic [3:0] OP_JMP = 4'd7;
  localparam logic [3:0] OP_JPC = 4'd8;
  localparam logic [3:0] OP_SYS = 4'd9;

  localparam logic signed [31:0] OPR_RET = 32'sd0;
  localparam logic signed [31:0] OPR_NEG = 32'sd1;
  localparam logic signed [31:0] OPR_ADD = 32'sd2;
  localparam logic signed [31:0] OPR_SUB = 32'sd3;
  localparam logic signed [31:0] OPR_MUL = 32'sd4;
  localparam logic signed [31:0] OPR_DIV = 32'sd5;
  localparam logic signed [31:0] OPR_ODD = 32'sd6;
  localparam logic signed [31:0] OPR_MOD = 32'sd7;
  localparam logic signed [31:0] OPR_EQL = 32'sd8;
  localparam logic signed [31:0] OPR_NEQ = 32'sd9;
  localparam logic signed [31:0] OPR_LSS = 32'sd10;
  localparam logic signed [31:0] OPR_LEQ = 32'sd11;
  localparam logic signed [31:0] OPR_GTR = 32'sd12;
  localparam logic signed [31:0] OPR_GEQ = 32'sd13;

  localparam logic signed [31:0] SYS_PRINT = 32'sd1;
  localparam logic signed [31:0] SYS_READ  = 32'sd2;
  localparam logic signed [31:0] SYS_HALT  = 32'sd3;

  localparam logic [16:0] CODE_SPAN = 17'd65536;

  typedef enum logic [1:0] {
    AR_MUL = 2'd0,
    AR_DIV = 2'd1,
    AR_MOD = 2'd2
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic dz;
  } arith_sts_t;

endpackage

### rtl/core/stack_machine_executor_top.sv
// ----------------------------------------------------------------------------
// Stack machine executor
// Executes one fetched P-machine instruction per transaction on a stack
// memory with stack, base and program counter registers.
// ----------------------------------------------------------------------------
// One instruction per input transaction, one status result per instruction.
// After reset the stack memory is zeroed by a sweep over all STACK_DEPTH
// words, during which in_stall stays high. An instruction needs no stack
// read when it is a literal, read, increment, jump, halt, any instruction
// after halt or a range error caught at decode; print, conditional jump,
// negate and odd read the stack memory once, compare/add/sub twice and
// return three times. Load, store and call read it once after a walk of
// the static links with one read per hop, and multiply, divide and modulo
// also run in the bit-serial arithmetic unit. The next instruction is
// taken while the previous result waits in the output register.
`include "stack_machine_executor_top_macros.svh"

module stack_machine_executor_top #(
  parameter int STACK_DEPTH = 512,
  parameter int MAX_LEVEL   = 7,
  parameter int WORD_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic [2:0]         in_level,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_read_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_next_pc,
  output logic [8:0]         out_base_ptr_out,
  output logic signed [9:0]  out_stack_ptr_out,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value,
  output logic               out_halted,
  output logic               out_fault
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = AW + 1;
  localparam int LVW = $clog2(MAX_LEVEL + 1);
  localparam int W   = WORD_BITS;
  localparam int XW  = smx_pkg::EXT_W;
  localparam int WW  = smx_pkg::WIDE_W;
  localparam logic signed [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);
  localparam logic [WW-1:0] DEPTH_W = WW'(STACK_DEPTH);
  localparam logic [WW-1:0] CODE_W  = WW'(smx_pkg::CODE_SPAN);
  localparam logic signed [XW-1:0] CODE_MAX_X = XW'(smx_pkg::CODE_SPAN) - XW'(1);
  localparam logic [7:0] LV_MAX = 8'(MAX_LEVEL);

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_DEC   = 11'b000_0000_0100,
    S_WALK  = 11'b000_0000_1000,
    S_WALKW = 11'b000_0001_0000,
    S_RD    = 11'b000_0010_0000,
    S_RD2   = 11'b000_0100_0000,
    S_RD3   = 11'b000_1000_0000,
    S_MUL   = 11'b001_0000_0000,
    S_WR    = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  function automatic logic in_stk(input logic signed [XW-1:0] x);
    return (x >= 0) && (x < DEPTH_X);
  endfunction

  function automatic logic in_code(input logic signed [XW-1:0] x);
    return (x >= 0) && (x <= CODE_MAX_X);
  endfunction

  function automatic logic word_stk(input logic [W-1:0] w);
    return !w[W-1] && (WW'(w) < DEPTH_W);
  endfunction

  function automatic logic word_code(input logic [W-1:0] w);
    return !w[W-1] && (WW'(w) < CODE_W);
  endfunction

  state_t                state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic signed [SPW-1:0] sp_r, sp_nxt;
  logic [AW-1:0]         bp_r, bp_nxt;
  logic [15:0]           pc_r, pc_nxt;
  logic                  halt_r, halt_nxt;
  logic [LVW-1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]         wb_r, wb_nxt;
  logic [AW-1:0]         tgt_r, tgt_nxt;
  logic [W-1:0]          y_r, y_nxt;
  logic [W-1:0]          nb_r, nb_nxt;
  logic [W-1:0]          np_r, np_nxt;
  logic [W-1:0]          top_r, top_nxt;
  logic [1:0]            step_r, step_nxt;
  logic                  pv_r, pv_nxt;
  logic [31:0]           pval_r, pval_nxt;
  logic                  fault_r, fault_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [3:0]            mode_r;
  logic signed [31:0]    m_r;
  logic signed [31:0]    rv_r;
  logic [15:0]           out_pc_r;
  logic [8:0]            out_bp_r;
  logic signed [9:0]     out_sp_r;
  logic                  out_pv_r;
  logic [31:0]           out_pval_r;
  logic                  out_halt_r;
  logic                  out_fault_r;

  logic [W-1:0]          stack_mem [STACK_DEPTH];
  logic [W-1:0]          rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [W-1:0]          mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;

  smx_pkg::arith_req_t   arith_req;
  smx_pkg::arith_sts_t   arith_sts;
  logic [W-1:0]          arith_res;

  logic signed [XW-1:0]  spx, bpx, mx, wbx, tgtx, incx;
  logic signed [WW-1:0]  m_wide, rv_wide;
  logic [WW-1:0]         d_wide, bp_wide, wb_wide, pc_wide, nb_wide, np_wide;
  logic [AW-1:0]         a_sp, a_sp_p1, a_sp_p2, a_sp_p3, a_sp_p4, a_sp_m1;
  logic [AW-1:0]         a_bp_p1, a_bp_p2, a_bp_m1, a_tgt;
  logic                  is_ret, is_un, is_bin, is_mdm;
  logic [W-1:0]          bin_res;
  logic [7:0]            lv_ext, lv_clamp;
  logic                  fin_load;

  always_comb begin
    spx     = XW'(sp_r);
    bpx     = XW'({1'b0, bp_r});
    mx      = XW'(m_r);
    wbx     = XW'({1'b0, wb_r});
    tgtx    = wbx + mx;
    incx    = spx + mx;
    m_wide  = WW'(m_r);
    rv_wide = WW'(rv_r);
    d_wide  = WW'(rd_data_r);
    bp_wide = WW'(bp_r);
    wb_wide = WW'(wb_r);
    pc_wide = WW'(pc_r);
    nb_wide = WW'(nb_r);
    np_wide = WW'(np_r);
    a_sp    = sp_r[AW-1:0];
    a_sp_p1 = AW'(spx + 1);
    a_sp_p2 = AW'(spx + 2);
    a_sp_p3 = AW'(spx + 3);
    a_sp_p4 = AW'(spx + 4);
    a_sp_m1 = AW'(spx - 1);
    a_bp_p1 = AW'(bpx + 1);
    a_bp_p2 = AW'(bpx + 2);
    a_bp_m1 = AW'(bpx - 1);
    a_tgt   = AW'(tgtx);
    is_ret  = (m_r == smx_pkg::OPR_RET);
    is_un   = (m_r == smx_pkg::OPR_NEG) || (m_r == smx_pkg::OPR_ODD);
    is_bin  = (m_r >= smx_pkg::OPR_ADD) && (m_r <= smx_pkg::OPR_GEQ) && !is_un;
    is_mdm  = (m_r == smx_pkg::OPR_MUL) || (m_r == smx_pkg::OPR_DIV) ||
              (m_r == smx_pkg::OPR_MOD);
    lv_ext   = {5'b0, in_level};
    lv_clamp = (lv_ext > LV_MAX) ? LV_MAX : lv_ext;
    fin_load = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    case (m_r)
      smx_pkg::OPR_ADD: bin_res = rd_data_r + y_r;
      smx_pkg::OPR_SUB: bin_res = rd_data_r - y_r;
      smx_pkg::OPR_EQL: bin_res = W'(rd_data_r == y_r);
      smx_pkg::OPR_NEQ: bin_res = W'(rd_data_r != y_r);
      smx_pkg::OPR_LSS: bin_res = W'($signed(rd_data_r) < $signed(y_r));
      smx_pkg::OPR_LEQ: bin_res = W'($signed(rd_data_r) <= $signed(y_r));
      smx_pkg::OPR_GTR: bin_res = W'($signed(rd_data_r) > $signed(y_r));
      smx_pkg::OPR_GEQ: bin_res = W'($signed(rd_data_r) >= $signed(y_r));
      default:          bin_res = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    sp_nxt    = sp_r;
    bp_nxt    = bp_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    cnt_nxt   = cnt_r;
    wb_nxt    = wb_r;
    tgt_nxt   = tgt_r;
    y_nxt     = y_r;
    nb_nxt    = nb_r;
    np_nxt    = np_r;
    top_nxt   = top_r;
    step_nxt  = step_r;
    pv_nxt    = pv_r;
    pval_nxt  = pval_r;
    fault_nxt = fault_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    arith_req.start = 1'b0;
    arith_req.op    = smx_pkg::AR_MUL;
    unique case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(STACK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt   = LVW'(lv_clamp);
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        pv_nxt    = 1'b0;
        pval_nxt  = '0;
        fault_nxt = 1'b0;
        state_nxt = S_FIN;
        wb_nxt    = bp_r;
        if (!halt_r) begin
          pc_nxt = pc_r + 16'd1;
          unique case (mode_r)
            smx_pkg::OP_LIT: begin
              if (in_stk(spx + 1)) begin
                mem_we    = 1'b1;
                mem_waddr = a_sp_p1;
                mem_wdata = m_wide[W-1:0];
                sp_nxt    = SPW'(spx + 1);
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_OPR: begin
              if (is_ret) begin
                if (in_stk(spx) && in_stk(bpx - 1) && in_stk(bpx + 2)) begin
                  mem_re    = 1'b1;
                  mem_raddr = a_bp_p1;
                  state_nxt = S_RD;
                end else begin
                  fault_nxt = 1'b1;
                end
              end else if (is_un || is_bin) begin
                if (in_stk(spx) && (is_un || in_stk(spx - 1))) begin
                  mem_re    = 1'b1;
                  mem_raddr = a_sp;
                  state_nxt = S_RD;
                end else begin
                  fault_nxt = 1'b1;
                end
              end
            end
            smx_pkg::OP_LOD: begin
              if (in_stk(spx + 1)) begin
                state_nxt = S_WALK;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_STO: begin
              if (in_stk(spx)) begin
                state_nxt = S_WALK;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_CAL: begin
              if (in_stk(spx) && in_stk(spx + 4) && in_code(mx)) begin
                state_nxt = S_WALK;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_INC: begin
              if ((incx >= -1) && (incx <= DEPTH_X - 1)) begin
                sp_nxt = SPW'(incx);
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_JMP: begin
              if (in_code(mx)) begin
                pc_nxt = m_r[15:0];
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_JPC: begin
              if (in_stk(spx)) begin
                mem_re    = 1'b1;
                mem_raddr = a_sp;
                state_nxt = S_RD;
              end else begin
                fault_nxt = 1'b1;
              end
            end
            smx_pkg::OP_SYS: begin
              if (m_r == smx_pkg::SYS_PRINT) begin
                if (in_stk(spx)) begin
                  mem_re    = 1'b1;
                  mem_raddr = a_sp;
                  state_nxt = S_RD;
                end else begin
                  fault_nxt = 1'b1;
                end
              end else if (m_r == smx_pkg::SYS_READ) begin
                if (in_stk(spx + 1)) begin
                  mem_we    = 1'b1;
                  mem_waddr = a_sp_p1;
                  mem_wdata = rv_wide[W-1:0];
                  sp_nxt    = SPW'(spx + 1);
                end else begin
                  fault_nxt = 1'b1;
                end
              end else if (m_r == smx_pkg::SYS_HALT) begin
                halt_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (cnt_r == '0) begin
          state_nxt = S_RD;
          tgt_nxt   = a_tgt;
          if (mode_r == smx_pkg::OP_LOD) begin
            if (in_stk(tgtx)) begin
              mem_re    = 1'b1;
              mem_raddr = a_tgt;
            end else begin
              fault_nxt = 1'b1;
              state_nxt = S_FIN;
            end
          end else if (mode_r == smx_pkg::OP_STO) begin
            if (in_stk(tgtx)) begin
              mem_re    = 1'b1;
              mem_raddr = a_sp;
            end else begin
              fault_nxt = 1'b1;
              state_nxt = S_FIN;
            end
          end else begin
            mem_re    = 1'b1;
            mem_raddr = a_sp;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wb_r;
          state_nxt = S_WALKW;
        end
      end
      S_WALKW: begin
        if (word_stk(rd_data_r)) begin
          wb_nxt    = d_wide[AW-1:0];
          cnt_nxt   = cnt_r - LVW'(1);
          state_nxt = S_WALK;
        end else begin
          fault_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_RD: begin
        state_nxt = S_FIN;
        unique case (mode_r)
          smx_pkg::OP_SYS: begin
            pv_nxt   = 1'b1;
            pval_nxt = d_wide[31:0];
            sp_nxt   = SPW'(spx - 1);
          end
          smx_pkg::OP_JPC: begin
            if (rd_data_r == '0) begin
              if (in_code(mx)) begin
                pc_nxt = m_r[15:0];
                sp_nxt = SPW'(spx - 1);
              end else begin
                fault_nxt = 1'b1;
              end
            end else begin
              sp_nxt = SPW'(spx - 1);
            end
          end
          smx_pkg::OP_OPR: begin
            if (is_ret) begin
              nb_nxt    = rd_data_r;
              mem_re    = 1'b1;
              mem_raddr = a_bp_p2;
              state_nxt = S_RD2;
            end else if (m_r == smx_pkg::OPR_NEG) begin
              mem_we    = 1'b1;
              mem_waddr = a_sp;
              mem_wdata = '0 - rd_data_r;
            end else if (m_r == smx_pkg::OPR_ODD) begin
              mem_we    = 1'b1;
              mem_waddr = a_sp;
              if (rd_data_r[0]) begin
                mem_wdata = rd_data_r[W-1] ? {W{1'b1}} : W'(1);
              end else begin
                mem_wdata = '0;
              end
            end else begin
              y_nxt     = rd_data_r;
              mem_re    = 1'b1;
              mem_raddr = a_sp_m1;
              state_nxt = S_RD2;
            end
          end
          smx_pkg::OP_LOD: begin
            mem_we    = 1'b1;
            mem_waddr = a_sp_p1;
            mem_wdata = rd_data_r;
            sp_nxt    = SPW'(spx + 1);
          end
          smx_pkg::OP_STO: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_r;
            mem_wdata = rd_data_r;
            sp_nxt    = SPW'(spx - 1);
          end
          smx_pkg::OP_CAL: begin
            top_nxt   = rd_data_r;
            mem_we    = 1'b1;
            mem_waddr = a_sp_p1;
            mem_wdata = wb_wide[W-1:0];
            step_nxt  = 2'd0;
            state_nxt = S_WR;
          end
          default: begin
          end
        endcase
      end
      S_RD2: begin
        if (is_ret) begin
          np_nxt    = rd_data_r;
          mem_re    = 1'b1;
          mem_raddr = a_sp;
          state_nxt = S_RD3;
        end else if (is_mdm) begin
          arith_req.start = 1'b1;
          if (m_r == smx_pkg::OPR_MUL) begin
            arith_req.op = smx_pkg::AR_MUL;
          end else if (m_r == smx_pkg::OPR_DIV) begin
            arith_req.op = smx_pkg::AR_DIV;
          end else begin
            arith_req.op = smx_pkg::AR_MOD;
          end
          state_nxt = S_MUL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = a_sp_m1;
          mem_wdata = bin_res;
          sp_nxt    = SPW'(spx - 1);
          state_nxt = S_FIN;
        end
      end
      S_RD3: begin
        state_nxt = S_FIN;
        if (word_stk(nb_r) && word_code(np_r)) begin
          mem_we    = 1'b1;
          mem_waddr = a_bp_m1;
          mem_wdata = rd_data_r;
          sp_nxt    = SPW'(bpx - 1);
          bp_nxt    = nb_wide[AW-1:0];
          pc_nxt    = np_wide[15:0];
        end else begin
          fault_nxt = 1'b1;
        end
      end
      S_MUL: begin
        if (arith_sts.done) begin
          mem_we    = 1'b1;
          mem_waddr = a_sp_m1;
          mem_wdata = arith_res;
          sp_nxt    = SPW'(spx - 1);
          fault_nxt = arith_sts.dz;
          state_nxt = S_FIN;
        end
      end
      S_WR: begin
        mem_we   = 1'b1;
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: begin
            mem_waddr = a_sp_p2;
            mem_wdata = bp_wide[W-1:0];
          end
          2'd1: begin
            mem_waddr = a_sp_p3;
            mem_wdata = pc_wide[W-1:0];
          end
          default: begin
            mem_waddr = a_sp_p4;
            mem_wdata = top_r;
            bp_nxt    = a_sp_p1;
            pc_nxt    = m_r[15:0];
            state_nxt = S_FIN;
          end
        endcase
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      sp_r        <= '1;
      bp_r        <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      bp_r        <= bp_nxt;
      pc_r        <= pc_nxt;
      halt_r      <= halt_nxt;
      cnt_r       <= cnt_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wb_r    <= wb_nxt;
    tgt_r   <= tgt_nxt;
    y_r     <= y_nxt;
    nb_r    <= nb_nxt;
    np_r    <= np_nxt;
    top_r   <= top_nxt;
    pv_r    <= pv_nxt;
    pval_r  <= pval_nxt;
    fault_r <= fault_nxt;
    if (in_valid && !in_stall) begin
      mode_r <= in_mode;
      m_r    <= in_operand;
      rv_r   <= in_read_value;
    end
    if (fin_load) begin
      out_pc_r    <= pc_r;
      out_bp_r    <= bp_wide[8:0];
      out_sp_r    <= spx[9:0];
      out_pv_r    <= pv_r;
      out_pval_r  <= pval_r;
      out_halt_r  <= halt_r;
      out_fault_r <= fault_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_raddr];
    end
  end

  smx_arith #(
    .WORD_BITS (WORD_BITS)
  ) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .opa   (rd_data_r),
    .opb   (y_r),
    .sts   (arith_sts),
    .res   (arith_res)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_next_pc       = out_pc_r;
  assign out_base_ptr_out  = out_bp_r;
  assign out_stack_ptr_out = out_sp_r;
  assign out_print_valid   = out_pv_r;
  assign out_print_value   = out_pval_r;
  assign out_halted        = out_halt_r;
  assign out_fault         = out_fault_r;

  `SMX_ASSERT_IMP(a_sp_range, 1'b1, (spx >= -1) && (spx < DEPTH_X), "stack pointer out of range")
  `SMX_ASSERT_NXT(a_halt_sticky, halt_r, halt_r, "halt flag dropped before reset")
  `SMX_ASSERT_IMP(a_arith_owner, arith_sts.done, state_r == S_MUL, "arithmetic done outside wait")
  `SMX_ASSERT_NXT(a_fin_load, fin_load, out_valid_r && (out_pc_r == $past(pc_r)), "result not loaded")

endmodule

### rtl/core/smx_arith.sv
// ----------------------------------------------------------------------------
// Stack machine executor arithmetic unit
// Radix-2 shift-add multiplier and restoring signed divider, one bit a cycle.
// ----------------------------------------------------------------------------
module smx_arith #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  smx_pkg::arith_req_t    req,
  input  logic [WORD_BITS-1:0]   opa,
  input  logic [WORD_BITS-1:0]   opb,
  output smx_pkg::arith_sts_t    sts,
  output logic [WORD_BITS-1:0]   res
);

  localparam int CW = $clog2(WORD_BITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CW-1:0]         cnt_r;
  smx_pkg::arith_op_t    op_r;
  logic [WORD_BITS-1:0]  acc_r;
  logic [WORD_BITS-1:0]  qa_r;
  logic [WORD_BITS-1:0]  qb_r;
  logic                  negq_r;
  logic                  negr_r;
  logic                  dz_r;
  logic [WORD_BITS:0]    sh_w;
  logic [WORD_BITS:0]    diff_w;
  logic                  ge_w;
  logic [WORD_BITS-1:0]  ua_w;
  logic [WORD_BITS-1:0]  ub_w;

  always_comb begin
    sh_w   = {acc_r, qa_r[WORD_BITS-1]};
    diff_w = sh_w - {1'b0, qb_r};
    ge_w   = sh_w >= {1'b0, qb_r};
    ua_w   = opa[WORD_BITS-1] ? ('0 - opa) : opa;
    ub_w   = opb[WORD_BITS-1] ? ('0 - opb) : opb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(WORD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      acc_r <= '0;
      if (req.op == smx_pkg::AR_MUL) begin
        qa_r <= opa;
        qb_r <= opb;
      end else begin
        qa_r <= ua_w;
        qb_r <= ub_w;
      end
      negq_r <= opa[WORD_BITS-1] ^ opb[WORD_BITS-1];
      negr_r <= opa[WORD_BITS-1];
      dz_r   <= (req.op != smx_pkg::AR_MUL) && (opb == '0);
    end else if (busy_r) begin
      if (op_r == smx_pkg::AR_MUL) begin
        if (qb_r[0]) begin
          acc_r <= acc_r + qa_r;
        end
        qa_r <= {qa_r[WORD_BITS-2:0], 1'b0};
        qb_r <= {1'b0, qb_r[WORD_BITS-1:1]};
      end else begin
        if (ge_w) begin
          acc_r <= diff_w[WORD_BITS-1:0];
          qa_r  <= {qa_r[WORD_BITS-2:0], 1'b1};
        end else begin
          acc_r <= sh_w[WORD_BITS-1:0];
          qa_r  <= {qa_r[WORD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (dz_r) begin
      res = '0;
    end else begin
      case (op_r)
        smx_pkg::AR_MUL: res = acc_r;
        smx_pkg::AR_DIV: res = negq_r ? ('0 - qa_r) : qa_r;
        default:         res = negr_r ? ('0 - acc_r) : acc_r;
      endcase
    end
  end

  assign sts.done = done_r;
  assign sts.dz   = dz_r;

endmodule

### sim/stack_machine_executor_checker.sv
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Watches the instruction and status channels, runs its own P-machine
// interpreter on every accepted instruction and compares each status
// transaction field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_executor_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_mode,
  input  logic [2:0]         in_level,
  input  logic signed [31:0] in_operand,
  input  logic signed [31:0] in_read_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_next_pc,
  input  logic [8:0]         out_base_ptr_out,
  input  logic signed [9:0]  out_stack_ptr_out,
  input  logic               out_print_valid,
  input  logic signed [31:0] out_print_value,
  input  logic               out_halted,
  input  logic               out_fault,
  output int                 fail_count,
  output int                 status_pending
);

  localparam int DEPTH = 512;

  typedef struct packed {
    logic [15:0]        pc;
    logic [8:0]         bp;
    logic signed [9:0]  sp;
    logic               pv;
    logic signed [31:0] pval;
    logic               halted;
    logic               fault;
  } status_t;

  logic signed [31:0] stk [DEPTH];
  int                 sp_q;
  int                 bp_q;
  logic [15:0]        pc_q;
  logic               halt_q;
  status_t            status_q [$];

  function automatic bit in_stk(longint i);
    return i >= 0 && i < DEPTH;
  endfunction

  function automatic bit in_code(longint t);
    return t >= 0 && t <= 65535;
  endfunction

  function automatic bit walk_links(int lv, output longint b);
    b = longint'(bp_q);
    repeat (lv) begin
      if (!in_stk(b)) return 0;
      b = longint'(stk[b]);
    end
    return in_stk(b);
  endfunction

  task automatic execute(input logic [3:0] mode, input logic [2:0] level,
                         input logic signed [31:0] m, input logic signed [31:0] rv,
                         output status_t st);
    longint             nsp, nbp, npc, b, nb, np;
    logic signed [31:0] x, y, r, top;
    bit                 bad, dz, pv;
    logic signed [31:0] pval;
    nsp = longint'(sp_q); nbp = longint'(bp_q); npc = longint'(16'(pc_q + 16'd1));
    bad = 0; dz = 0; pv = 0; pval = 0;
    if (halt_q) begin
      st = '{pc_q, 9'(bp_q), 10'(sp_q), 1'b0, 32'sd0, 1'b1, 1'b0};
      return;
    end
    case (mode)
      smx_pkg::OP_LIT: begin
        if (!in_stk(nsp + 1)) bad = 1;
        else begin nsp++; stk[nsp] = m; end
      end
      smx_pkg::OP_OPR: begin
        if (m == smx_pkg::OPR_RET) begin
          if (!in_stk(nsp) || !in_stk(nbp - 1) || !in_stk(nbp + 2)) bad = 1;
          else begin
            nb = longint'(stk[nbp + 1]);
            np = longint'(stk[nbp + 2]);
            if (!in_stk(nb) || !in_code(np)) bad = 1;
            else begin
              stk[nbp - 1] = stk[nsp];
              nsp = nbp - 1; nbp = nb; npc = np;
            end
          end
        end else if (m == smx_pkg::OPR_NEG || m == smx_pkg::OPR_ODD) begin
          if (!in_stk(nsp)) bad = 1;
          else if (m == smx_pkg::OPR_NEG) stk[nsp] = -stk[nsp];
          else stk[nsp] = stk[nsp] % 2;
        end else if (m >= smx_pkg::OPR_ADD && m <= smx_pkg::OPR_GEQ) begin
          if (!in_stk(nsp) || !in_stk(nsp - 1)) bad = 1;
          else begin
            x = stk[nsp - 1];
            y = stk[nsp];
            case (m)
              smx_pkg::OPR_ADD: r = x + y;
              smx_pkg::OPR_SUB: r = x - y;
              smx_pkg::OPR_MUL: r = x * y;
              smx_pkg::OPR_DIV, smx_pkg::OPR_MOD: begin
                if (y == 0) begin dz = 1; r = 0; end
                else if (m == smx_pkg::OPR_DIV) r = 32'(longint'(x) / longint'(y));
                else r = 32'(longint'(x) % longint'(y));
              end
              smx_pkg::OPR_EQL: r = 32'(x == y);
              smx_pkg::OPR_NEQ: r = 32'(x != y);
              smx_pkg::OPR_LSS: r = 32'(x < y);
              smx_pkg::OPR_LEQ: r = 32'(x <= y);
              smx_pkg::OPR_GTR: r = 32'(x > y);
              default:          r = 32'(x >= y);
            endcase
            nsp--;
            stk[nsp] = r;
          end
        end
      end
      smx_pkg::OP_LOD: begin
        if (!in_stk(nsp + 1) || !walk_links(level, b) || !in_stk(b + m)) bad = 1;
        else begin nsp++; stk[nsp] = stk[b + m]; end
      end
      smx_pkg::OP_STO: begin
        if (!in_stk(nsp) || !walk_links(level, b) || !in_stk(b + m)) bad = 1;
        else begin stk[b + m] = stk[nsp]; nsp--; end
      end
      smx_pkg::OP_CAL: begin
        if (!in_stk(nsp) || !in_stk(nsp + 4) || !walk_links(level, b) || !in_code(m))
          bad = 1;
        else begin
          top = stk[nsp];
          stk[nsp + 1] = 32'(b);
          stk[nsp + 2] = 32'(nbp);
          stk[nsp + 3] = 32'(npc);
          stk[nsp + 4] = top;
          nbp = nsp + 1;
          npc = longint'(m);
        end
      end
      smx_pkg::OP_INC: begin
        if (nsp + m < -1 || nsp + m > DEPTH - 1) bad = 1;
        else nsp += m;
      end
      smx_pkg::OP_JMP: begin
        if (!in_code(m)) bad = 1;
        else npc = longint'(m);
      end
      smx_pkg::OP_JPC: begin
        if (!in_stk(nsp)) bad = 1;
        else if (stk[nsp] == 0 && !in_code(m)) bad = 1;
        else begin
          if (stk[nsp] == 0) npc = longint'(m);
          nsp--;
        end
      end
      smx_pkg::OP_SYS: begin
        if (m == smx_pkg::SYS_PRINT) begin
          if (!in_stk(nsp)) bad = 1;
          else begin pv = 1; pval = stk[nsp]; nsp--; end
        end else if (m == smx_pkg::SYS_READ) begin
          if (!in_stk(nsp + 1)) bad = 1;
          else begin nsp++; stk[nsp] = rv; end
        end else if (m == smx_pkg::SYS_HALT) begin
          halt_q = 1;
        end
      end
      default: ;
    endcase
    if (bad) begin
      nsp = longint'(sp_q); nbp = longint'(bp_q); npc = longint'(16'(pc_q + 16'd1));
      pv = 0; pval = 0;
    end
    sp_q = int'(nsp);
    bp_q = int'(nbp);
    pc_q = 16'(npc);
    st = '{pc_q, 9'(bp_q), 10'(sp_q), pv, pval, halt_q, bad || dz};
  endtask

  initial begin
    foreach (stk[i]) stk[i] = '0;
    sp_q = -1; bp_q = 0; pc_q = '0; halt_q = 0;
    fail_count = 0;
  end

  assign status_pending = status_q.size();

  always @(posedge clk) begin
    status_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_next_pc, out_base_ptr_out, out_stack_ptr_out, out_print_valid,
                out_print_value, out_halted, out_fault};
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status transaction %p", $time, got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            $display("%0t: status mismatch expected %p actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        execute(in_mode, in_level, in_operand, in_read_value, want);
        status_q.push_back(want);
      end
    end
  end

endmodule

### sim/stack_machine_executor_top_test.sv
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Drives directed and random instruction streams through the executor with
// random idling on both channels and a long output hold-off, then a halt
// followed by further random instructions, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_machine_executor_top_test;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         in_mode;
  logic [2:0]         in_level;
  logic signed [31:0] in_operand;
  logic signed [31:0] in_read_value;
  logic               out_valid;
  logic               out_stall;
  logic [15:0]        out_next_pc;
  logic [8:0]         out_base_ptr_out;
  logic signed [9:0]  out_stack_ptr_out;
  logic               out_print_valid;
  logic signed [31:0] out_print_value;
  logic               out_halted;
  logic               out_fault;
  int                 fail_count;
  int                 status_pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 hold_left;

  stack_machine_executor_top u_top (.*);

  stack_machine_executor_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic send(input logic [3:0] mode, input logic [2:0] level,
                      input logic signed [31:0] operand, input logic signed [31:0] rv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 0;
    end
    @(negedge clk);
    in_valid      <= 1;
    in_mode       <= mode;
    in_level      <= level;
    in_operand    <= operand;
    in_read_value <= rv;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return -32'sd1;
      2: return 32'sd0;
      3: return 32'sh7fff_ffff;
      4: return $urandom;
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  task automatic send_random();
    int                 r;
    logic [2:0]         lv;
    logic signed [31:0] op;
    r  = $urandom_range(0, 99);
    lv = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1));
    if (r < 25) send(smx_pkg::OP_LIT, 3'($urandom), pick_word(), $urandom);
    else if (r < 45) begin
      op = ($urandom_range(0, 19) == 0) ? 32'($urandom) : 32'($urandom_range(0, 13));
      send(smx_pkg::OP_OPR, 3'($urandom), op, $urandom);
    end else if (r < 52) send(smx_pkg::OP_LOD, lv, $urandom_range(0, 8) - 2, $urandom);
    else if (r < 59) send(smx_pkg::OP_STO, lv, $urandom_range(0, 8) - 2, $urandom);
    else if (r < 64) begin
      op = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 300));
      send(smx_pkg::OP_CAL, lv, op, $urandom);
    end else if (r < 70) send(smx_pkg::OP_INC, 3'($urandom), $urandom_range(0, 6) - 3,
                              $urandom);
    else if (r < 75) send(smx_pkg::OP_JMP, 3'($urandom), $urandom_range(0, 3) == 0 ?
                          32'($urandom) : 32'($urandom_range(0, 65535)), $urandom);
    else if (r < 82) send(smx_pkg::OP_JPC, 3'($urandom), $urandom_range(0, 3) == 0 ?
                          32'($urandom) : 32'($urandom_range(0, 65535)), $urandom);
    else if (r < 95) begin
      case ($urandom_range(0, 4))
        0, 1: op = smx_pkg::SYS_PRINT;
        2, 3: op = smx_pkg::SYS_READ;
        default: op = $urandom;
      endcase
      if (op == smx_pkg::SYS_HALT) op = 32'sd4;
      send(smx_pkg::OP_SYS, 3'($urandom), op, $urandom);
    end else begin
      send($urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(10, 15)), 3'($urandom),
           $urandom, $urandom);
    end
  endtask

  initial begin
    rst_n          = 0;
    in_valid       = 0;
    in_mode        = '0;
    in_level       = '0;
    in_operand     = '0;
    in_read_value  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;

    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_ADD, 32'sd0);
    send(smx_pkg::OP_INC, 3'd7, 32'sd512, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, 32'sd1, 32'sd0);
    send(smx_pkg::OP_INC, 3'd0, -32'sd512, 32'sd0);
    send(smx_pkg::OP_INC, 3'd0, 32'sh8000_0000, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, 32'sh7fff_ffff, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, 32'sh8000_0000, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_ADD, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, 32'sh8000_0000, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, -32'sd1, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_DIV, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, -32'sd7, 32'sd0);
    send(smx_pkg::OP_LIT, 3'd0, 32'sd0, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_MOD, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_NEG, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_ODD, 32'sd0);
    send(smx_pkg::OP_CAL, 3'd7, 32'sd40, 32'sd0);
    send(smx_pkg::OP_LOD, 3'd1, 32'sd3, 32'sd0);
    send(smx_pkg::OP_STO, 3'd0, 32'sh7fff_ffff, 32'sd0);
    send(smx_pkg::OP_OPR, 3'd0, smx_pkg::OPR_RET, 32'sd0);
    send(smx_pkg::OP_JMP, 3'd0, -32'sd1, 32'sd0);
    send(smx_pkg::OP_JPC, 3'd0, 32'sd65535, 32'sd0);
    send(smx_pkg::OP_SYS, 3'd0, smx_pkg::SYS_READ, 32'sh8000_0000);
    send(smx_pkg::OP_SYS, 3'd0, smx_pkg::SYS_PRINT, 32'sh7fff_ffff);
    send(4'd15, 3'd7, 32'sd99, -32'sd1);

    send_idle_pct = 24; recv_stall_pct = 59;
    repeat (300) send_random();
    send_idle_pct = 59; recv_stall_pct = 24;
    repeat (300) send_random();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_left = 400;
    repeat (300) send_random();

    send(smx_pkg::OP_SYS, 3'd0, smx_pkg::SYS_HALT, 32'sd0);
    repeat (4) send_random();
    @(negedge clk);
    in_valid <= 0;

    while (status_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/smx_pkg.sv
rtl/core/smx_arith.sv
rtl/core/stack_machine_executor_top.sv
sim/stack_machine_executor_checker.sv
sim/stack_machine_executor_top_test.sv
